### hw/rtl/gbtc_pkg.sv
// Package with shared types and constants of the bipartite two-colouring block.
package gbtc_pkg;

    localparam int unsigned NODE_W  = 10;
    localparam int unsigned NODES   = 1 << NODE_W;
    localparam int unsigned EIDX_W  = 10;
    localparam int unsigned EDGES   = 1 << EIDX_W;
    localparam int unsigned ECNT_W  = EIDX_W + 1;
    localparam int unsigned HALF_W  = EIDX_W + 1;
    localparam int unsigned LINK_W  = HALF_W + 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(2 * EDGES);
    localparam int unsigned SP_W    = NODE_W + 1;

    // Item kinds.
    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_RUN   = 2'd1,
        K_QUERY = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    // Node colour codes.
    localparam logic [1:0] COL_NONE = 2'd0;
    localparam logic [1:0] COL_0    = 2'd1;
    localparam logic [1:0] COL_1    = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [EIDX_W-1:0] edge_index;
    } t_item;

    typedef struct packed {
        logic bipartite;
        logic orientation;
        logic overflow;
        logic index_bad;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_ADD1,
        S_ADD2,
        S_RCLR,
        S_RSTART,
        S_POP,
        S_LINK,
        S_VISIT,
        S_Q1,
        S_Q2,
        S_OUT
    } t_state;

endpackage

### hw/rtl/gbtc_item_if.sv
// Valid/ready channel interfaces for items and results.
interface gbtc_item_if;
    logic            valid;
    logic            ready;
    gbtc_pkg::t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gbtc_result_if;
    logic              valid;
    logic              ready;
    gbtc_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/gbtc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gbtc_ram #(
    parameter int unsigned DEPTH_W = 10,
    parameter int unsigned DATA_W  = 8
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [DEPTH_W-1:0] i_waddr,
    input  logic [DATA_W-1:0]  i_wdata,
    input  logic [DEPTH_W-1:0] i_raddr,
    output logic [DATA_W-1:0]  o_rdata
);
    logic [DATA_W-1:0] mem [0:(1<<DEPTH_W)-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

### hw/rtl/graph_bipartite_two_coloring.sv
// Top level of the bipartite two-colouring block: sequencer and its memories.
//
//  channel   dir  handshake      payload
//  i_item    in   valid/ready    kind, node_a, node_b, edge_index
//  o_res     out  valid/ready    bipartite, orientation, overflow, index_bad
//  cfg       in   i_cfg_we       i_cfg_data = start_node
//
// A clear sweeps one head and colour entry a cycle. A run clears every colour, seeds
// the stack with the start node, then examines each half-edge and pops each node whose
// links are done before it offers its result.
// After reset the block sweeps all 1024 adjacency heads and colours before
// it takes an item. A result waits in the output register until taken; the next item
// may be accepted meanwhile, but its result waits behind the one still offered.
module graph_bipartite_two_coloring (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gbtc_item_if.sink                 i_item,
    gbtc_result_if.source             o_res,
    input  logic                      i_cfg_we,
    input  logic [gbtc_pkg::NODE_W-1:0] i_cfg_data
);
    localparam int unsigned NW = gbtc_pkg::NODE_W;
    localparam int unsigned LW = gbtc_pkg::LINK_W;
    localparam int unsigned HW = gbtc_pkg::HALF_W;
    localparam int unsigned EW = gbtc_pkg::EIDX_W;
    localparam int unsigned SW = gbtc_pkg::SP_W;

    gbtc_pkg::t_state r_state, n_state;
    gbtc_pkg::t_item  r_item, n_item;
    logic [NW-1:0] r_start;
    logic [gbtc_pkg::ECNT_W-1:0] r_cnt, n_cnt;
    logic r_conf, n_conf, r_ovf, n_ovf;
    logic [NW:0] r_ctr, n_ctr;
    logic [SW-1:0] r_sp, n_sp;
    logic [NW-1:0] r_u, n_u;
    logic [1:0] r_ucol, n_ucol;
    logic [LW-1:0] r_h, n_h;
    logic [NW-1:0] r_v, n_v;
    logic r_ovalid, n_ovalid;
    gbtc_pkg::t_result r_res, n_res;
    gbtc_pkg::t_result r_out, n_out;

    // Memory ports.
    logic hd_we; logic [NW-1:0] hd_wa, hd_ra; logic [LW-1:0] hd_wd, hd_rd;
    logic cl_we; logic [NW-1:0] cl_wa, cl_ra; logic [1:0] cl_wd, cl_rd;
    logic ht_we; logic [HW-1:0] ht_wa, ht_ra; logic [NW-1:0] ht_wd, ht_rd;
    logic hn_we; logic [HW-1:0] hn_wa, hn_ra; logic [LW-1:0] hn_wd, hn_rd;
    logic fe_we; logic [EW-1:0] fe_wa, fe_ra; logic [NW-1:0] fe_wd, fe_rd;
    logic sk_we; logic [NW-1:0] sk_wa, sk_ra;
    logic [NW+LW-1:0] sk_wd, sk_rd;

    gbtc_ram #(.DEPTH_W(NW), .DATA_W(LW)) u_head (.i_clk, .i_we(hd_we), .i_waddr(hd_wa),
        .i_wdata(hd_wd), .i_raddr(hd_ra), .o_rdata(hd_rd));
    gbtc_ram #(.DEPTH_W(NW), .DATA_W(2)) u_col (.i_clk, .i_we(cl_we), .i_waddr(cl_wa),
        .i_wdata(cl_wd), .i_raddr(cl_ra), .o_rdata(cl_rd));
    gbtc_ram #(.DEPTH_W(HW), .DATA_W(NW)) u_tgt (.i_clk, .i_we(ht_we), .i_waddr(ht_wa),
        .i_wdata(ht_wd), .i_raddr(ht_ra), .o_rdata(ht_rd));
    gbtc_ram #(.DEPTH_W(HW), .DATA_W(LW)) u_nxt (.i_clk, .i_we(hn_we), .i_waddr(hn_wa),
        .i_wdata(hn_wd), .i_raddr(hn_ra), .o_rdata(hn_rd));
    gbtc_ram #(.DEPTH_W(EW), .DATA_W(NW)) u_first (.i_clk, .i_we(fe_we), .i_waddr(fe_wa),
        .i_wdata(fe_wd), .i_raddr(fe_ra), .o_rdata(fe_rd));
    gbtc_ram #(.DEPTH_W(NW), .DATA_W(NW+LW)) u_stack (.i_clk, .i_we(sk_we), .i_waddr(sk_wa),
        .i_wdata(sk_wd), .i_raddr(sk_ra), .o_rdata(sk_rd));

    assign i_item.ready  = (r_state == gbtc_pkg::S_IDLE);
    assign o_res.valid   = r_ovalid;
    assign o_res.payload = r_out;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gbtc_pkg::S_CLR;
            r_start  <= NW'(1);
            r_cnt    <= '0;
            r_conf   <= 1'b0;
            r_ovf    <= 1'b0;
            r_ctr    <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_conf   <= n_conf;
            r_ovf    <= n_ovf;
            r_ctr    <= n_ctr;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_start <= i_cfg_data;
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_u    <= n_u;
        r_ucol <= n_ucol;
        r_h    <= n_h;
        r_v    <= n_v;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // Next state, memory control and results.
    always_comb begin
        n_state = r_state; n_item = r_item; n_cnt = r_cnt; n_conf = r_conf;
        n_ovf = r_ovf; n_ctr = r_ctr; n_sp = r_sp; n_u = r_u; n_ucol = r_ucol;
        n_h = r_h; n_v = r_v; n_res = r_res; n_out = r_out;
        n_ovalid = r_ovalid && !o_res.ready;
        hd_we = 1'b0; hd_wa = r_ctr[NW-1:0]; hd_wd = gbtc_pkg::LINK_NULL; hd_ra = r_u;
        cl_we = 1'b0; cl_wa = r_ctr[NW-1:0]; cl_wd = gbtc_pkg::COL_NONE; cl_ra = r_v;
        ht_we = 1'b0; ht_wa = '0; ht_wd = '0; ht_ra = r_h[HW-1:0];
        hn_we = 1'b0; hn_wa = '0; hn_wd = '0; hn_ra = r_h[HW-1:0];
        fe_we = 1'b0; fe_wa = r_cnt[EW-1:0]; fe_wd = r_item.node_a;
        fe_ra = r_item.edge_index;
        sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = NW'(r_sp - SW'(1));
        case (r_state)
            gbtc_pkg::S_IDLE: begin
                if (i_item.valid && i_item.ready) begin
                    n_item = i_item.payload;
                    n_ctr = '0;
                    case (gbtc_pkg::t_kind'(i_item.payload.kind))
                        gbtc_pkg::K_ADD: begin
                            n_state = gbtc_pkg::S_ADD1;
                            n_u = i_item.payload.node_a;
                            hd_ra = i_item.payload.node_a;
                        end
                        gbtc_pkg::K_RUN:   n_state = gbtc_pkg::S_RCLR;
                        gbtc_pkg::K_QUERY: n_state = gbtc_pkg::S_Q1;
                        gbtc_pkg::K_CLEAR: begin
                            n_state = gbtc_pkg::S_CLR;
                            n_cnt = '0;
                        end
                        default: n_state = gbtc_pkg::S_IDLE;
                    endcase
                end
            end
            // Sweep heads and colours, one entry a cycle.
            gbtc_pkg::S_CLR: begin
                hd_we = 1'b1; cl_we = 1'b1; n_conf = 1'b0;
                n_ctr = r_ctr + 1'b1;
                if (r_ctr == (NW+1)'(gbtc_pkg::NODES - 1)) n_state = gbtc_pkg::S_IDLE;
            end
            // Head of node a is being read; then node b.
            gbtc_pkg::S_ADD1: begin
                if (r_cnt == gbtc_pkg::ECNT_W'(gbtc_pkg::EDGES)) begin
                    n_ovf = 1'b1; n_state = gbtc_pkg::S_IDLE;
                end else begin
                    hd_ra = r_item.node_b;
                    n_state = gbtc_pkg::S_ADD2;
                    // First half-edge goes to node a.
                    ht_we = 1'b1; hn_we = 1'b1; hd_we = 1'b1;
                    ht_wa = {r_cnt[EW-1:0], 1'b0}; ht_wd = r_item.node_b;
                    hn_wa = ht_wa; hn_wd = hd_rd;
                    hd_wa = r_item.node_a; hd_wd = LW'({r_cnt[EW-1:0], 1'b0});
                    fe_we = 1'b1;
                end
            end
            gbtc_pkg::S_ADD2: begin
                // Self-loop: node b's head is the half-edge just written.
                ht_we = 1'b1; hn_we = 1'b1; hd_we = 1'b1;
                ht_wa = {r_cnt[EW-1:0], 1'b1}; ht_wd = r_item.node_a;
                hn_wa = ht_wa;
                hn_wd = (r_item.node_a == r_item.node_b) ? LW'({r_cnt[EW-1:0], 1'b0}) : hd_rd;
                hd_wa = r_item.node_b; hd_wd = LW'({r_cnt[EW-1:0], 1'b1});
                n_cnt = r_cnt + 1'b1;
                n_state = gbtc_pkg::S_IDLE;
            end
            // Run: clear colours, then seed the stack.
            gbtc_pkg::S_RCLR: begin
                cl_we = 1'b1; n_conf = 1'b0;
                n_ctr = r_ctr + 1'b1;
                hd_ra = r_start;
                if (r_ctr == (NW+1)'(gbtc_pkg::NODES - 1)) n_state = gbtc_pkg::S_RSTART;
            end
            gbtc_pkg::S_RSTART: begin
                cl_we = 1'b1; cl_wa = r_start; cl_wd = gbtc_pkg::COL_0;
                sk_we = 1'b1; sk_wa = '0; sk_wd = {r_start, hd_rd};
                n_sp = SW'(1);
                n_state = gbtc_pkg::S_POP;
            end
            // Stack top is being read.
            gbtc_pkg::S_POP: begin
                if (r_sp == '0) begin
                    n_res = '{bipartite: !r_conf, orientation: 1'b0,
                              overflow: r_ovf, index_bad: 1'b0};
                    n_state = gbtc_pkg::S_OUT;
                end else begin
                    n_state = gbtc_pkg::S_LINK;
                end
            end
            // Top entry available; pop it if its link is null, else fetch the half-edge and node colour.
            gbtc_pkg::S_LINK: begin
                n_u = sk_rd[NW+LW-1:LW];
                n_h = sk_rd[LW-1:0];
                if (sk_rd[LW-1]) begin
                    n_sp = r_sp - SW'(1);
                    n_state = gbtc_pkg::S_POP;
                    sk_ra = NW'(r_sp - SW'(2));
                end else begin
                    ht_ra = sk_rd[HW-1:0]; hn_ra = sk_rd[HW-1:0];
                    cl_ra = sk_rd[NW+LW-1:LW];
                    n_state = gbtc_pkg::S_VISIT;
                end
            end
            // Target, next link and own colour read; read target colour and head, then colour and push.
            gbtc_pkg::S_VISIT: begin
                if (r_ctr[0] == 1'b0) begin
                    n_ucol = cl_rd;
                    n_v = ht_rd;
                    cl_ra = ht_rd; hd_ra = ht_rd;
                    sk_we = 1'b1; sk_wa = NW'(r_sp - SW'(1)); sk_wd = {r_u, hn_rd};
                    n_ctr[0] = 1'b1;
                end else begin
                    n_ctr[0] = 1'b0;
                    if (cl_rd == r_ucol) n_conf = 1'b1;
                    if (cl_rd == gbtc_pkg::COL_NONE && r_sp != SW'(gbtc_pkg::NODES)) begin
                        cl_we = 1'b1; cl_wa = r_v;
                        cl_wd = (r_ucol == gbtc_pkg::COL_0) ? gbtc_pkg::COL_1
                                                            : gbtc_pkg::COL_0;
                        sk_we = 1'b1; sk_wa = NW'(r_sp); sk_wd = {r_v, hd_rd};
                        n_sp = r_sp + SW'(1);
                        sk_ra = NW'(r_sp);
                    end
                    n_state = gbtc_pkg::S_POP;
                end
            end
            // Query: read first endpoint, then its colour.
            gbtc_pkg::S_Q1: begin
                n_state = gbtc_pkg::S_Q2;
            end
            gbtc_pkg::S_Q2: begin
                if (r_ctr[0] == 1'b0) begin
                    cl_ra = fe_rd; n_ctr[0] = 1'b1;
                end else begin
                    n_ctr[0] = 1'b0;
                    if ({1'b0, r_item.edge_index} >= r_cnt) begin
                        n_res = '{bipartite: !r_conf, orientation: 1'b0,
                                  overflow: r_ovf, index_bad: 1'b1};
                    end else begin
                        n_res = '{bipartite: !r_conf, orientation: (cl_rd == gbtc_pkg::COL_0),
                                  overflow: r_ovf, index_bad: 1'b0};
                    end
                    n_state = gbtc_pkg::S_OUT;
                end
            end
            // Move the result to the output register once it is free.
            gbtc_pkg::S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_out = r_res;
                    n_ovalid = 1'b1;
                    n_state = gbtc_pkg::S_IDLE;
                end
            end
            default: n_state = gbtc_pkg::S_IDLE;
        endcase
    end

    // A waiting result holds steady until it is taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_res.ready |=> r_ovalid && $stable(r_out))
        else $error("result changed while waiting");
    // The edge count never exceeds capacity.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= gbtc_pkg::ECNT_W'(gbtc_pkg::EDGES)) else $error("edge count overrun");
    // Overflow is sticky.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_ovf) && $past(i_rst_n) |-> r_ovf) else $error("overflow lost");
    // The stack never exceeds the node count.
    a_sp_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SW'(gbtc_pkg::NODES) || r_state == gbtc_pkg::S_IDLE)
        else $error("stack overrun");
endmodule

### verif/gbtc_checker.sv
// Checker of the bipartite two-colouring block: predicts every result and compares it.
module gbtc_checker
    import gbtc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    gbtc_item_if                item_ch,
    gbtc_result_if              res_ch,
    input  logic                i_cfg_we,
    input  logic [NODE_W-1:0]   i_cfg_data,
    output int                  o_fails,
    output int                  o_pending
);

    localparam int HALF_CAP = 2 * EDGES;

    // Predicted copy of the block's state.
    logic [NODE_W-1:0] walk_start;
    logic [1:0]        colour     [NODES];
    int                adj_head   [NODES];
    int                half_target[HALF_CAP];
    int                half_next  [HALF_CAP];
    int                first_end  [EDGES];
    int                stored_edges;
    logic              conflict;
    logic              dropped;
    int                stk_node   [NODES];
    int                stk_link   [NODES];

    t_result           expected_results[$];
    int                fails;

    assign o_fails   = fails;
    assign o_pending = expected_results.size();

    task automatic report(input string field, input logic want, input logic got);
        $display("mismatch on %s: expected %0b, got %0b", field, want, got);
        fails++;
    endtask

    function automatic void uncolour_all();
        for (int i = 0; i < NODES; i++) colour[i] = COL_NONE;
        conflict = 1'b0;
    endfunction

    function automatic void empty_store();
        for (int i = 0; i < NODES; i++) adj_head[i] = int'(LINK_NULL);
        stored_edges = 0;
        uncolour_all();
    endfunction

    function automatic void store_edge(input int a, input int b);
        int h;
        if (stored_edges >= EDGES) begin
            dropped = 1'b1;
            return;
        end
        h = 2 * stored_edges;
        half_target[h]     = b;
        half_next[h]       = adj_head[a];
        adj_head[a]        = h;
        half_target[h + 1] = a;
        half_next[h + 1]   = adj_head[b];
        adj_head[b]        = h + 1;
        first_end[stored_edges] = a;
        stored_edges++;
    endfunction

    // Depth-first colouring from the start node with an explicit stack.
    function automatic void colour_graph();
        int sp;
        int u;
        int h;
        int v;
        uncolour_all();
        colour[walk_start] = COL_0;
        stk_node[0] = walk_start;
        stk_link[0] = adj_head[walk_start];
        sp = 1;
        while (sp > 0) begin
            u = stk_node[sp - 1];
            h = stk_link[sp - 1];
            if (h >= HALF_CAP) begin
                sp--;
                continue;
            end
            stk_link[sp - 1] = half_next[h];
            v = half_target[h];
            if (colour[v] == colour[u]) conflict = 1'b1;
            if (colour[v] == COL_NONE && sp < NODES) begin
                colour[v] = (colour[u] == COL_0) ? COL_1 : COL_0;
                stk_node[sp] = v;
                stk_link[sp] = adj_head[v];
                sp++;
            end
        end
    endfunction

    function automatic void predict_item(input t_item it);
        t_result r;
        r = '0;
        case (t_kind'(it.kind))
            K_ADD: begin
                store_edge(int'(it.node_a), int'(it.node_b));
            end
            K_CLEAR: begin
                empty_store();
            end
            K_RUN: begin
                colour_graph();
                r.bipartite = !conflict;
                r.overflow  = dropped;
                expected_results = {expected_results, r};
            end
            default: begin
                r.bipartite = !conflict;
                r.overflow  = dropped;
                if (int'(it.edge_index) >= stored_edges) begin
                    r.index_bad = 1'b1;
                end else begin
                    r.orientation = (colour[first_end[it.edge_index]] == COL_0);
                end
                expected_results = {expected_results, r};
            end
        endcase
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            walk_start = NODE_W'(1);
            dropped    = 1'b0;
            fails      = 0;
            expected_results.delete();
            empty_store();
        end else begin
            if (i_cfg_we) walk_start = i_cfg_data;
            if (item_ch.valid && item_ch.ready) predict_item(item_ch.payload);
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.payload;
                if (expected_results.size() == 0) begin
                    report("result transfer", 1'b0, 1'b1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.bipartite !== want.bipartite)
                        report("bipartite", want.bipartite, got.bipartite);
                    if (got.orientation !== want.orientation)
                        report("orientation", want.orientation, got.orientation);
                    if (got.overflow !== want.overflow)
                        report("overflow", want.overflow, got.overflow);
                    if (got.index_bad !== want.index_bad)
                        report("index_bad", want.index_bad, got.index_bad);
                end
            end
        end
    end

endmodule

### verif/testbench.sv
// Top of the testbench: clock, reset, stimulus, receiver stalls, watchdog and verdict.
module testbench;
    import gbtc_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 1200;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [NODE_W-1:0] cfg_data;
    int                fails;
    int                pending;
    int                quiet_cycles;
    int                burst_left;
    int                stall_left;
    int                calm_left;
    logic [NODE_W-1:0] start_node;

    gbtc_item_if   item_ch ();
    gbtc_result_if res_ch ();

    graph_bipartite_two_coloring u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    gbtc_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .item_ch    (item_ch),
        .res_ch     (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on cycles in which no transfer happens on either channel.
    initial quiet_cycles = 0;
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stalls, with calm stretches of no stalling in between.
    initial begin
        res_ch.ready = 1'b0;
        stall_left   = 0;
        calm_left    = 0;
        forever begin
            @(negedge clk);
            if (calm_left > 0) begin
                calm_left--;
                res_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready = 1'b0;
            end else begin
                res_ch.ready = 1'b1;
                if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(200, 2000);
                else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 30);
            end
        end
    end

    // Offer one item and hold it until it is taken; the sender may pause between bursts.
    task automatic send(input t_kind kind, input int a, input int b, input int idx);
        if (burst_left == 0) begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        item_ch.valid   = 1'b1;
        item_ch.payload = '{kind: kind, node_a: NODE_W'(a), node_b: NODE_W'(b),
                            edge_index: EIDX_W'(idx)};
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    // Write the start node once the block has drained and settled.
    task automatic set_start(input logic [NODE_W-1:0] value);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        start_node = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random items, mostly around the start node; even-odd mode draws even-odd edges apart from random ones.
    task automatic random_phase(input int count, input int span);
        int     roll;
        int     k;
        logic   even_odd;
        logic [NODE_W-1:0] na;
        logic [NODE_W-1:0] nb;
        even_odd = 1'b1;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                k  = $urandom_range(0, span / 2);
                na = start_node + NODE_W'(2 * k);
                nb = start_node + NODE_W'(2 * $urandom_range(0, span / 2) + 1);
                if (!even_odd) nb = start_node + NODE_W'($urandom_range(0, span - 1));
                if ($urandom_range(0, 9) == 0) begin
                    na = NODE_W'($urandom);
                    nb = NODE_W'($urandom);
                end
                if ($urandom_range(0, 1) == 1) send(K_ADD, nb, na, $urandom);
                else send(K_ADD, na, nb, $urandom);
            end else if (roll < 70) begin
                send(K_RUN, $urandom, $urandom, $urandom);
            end else if (roll < 95) begin
                send(K_QUERY, $urandom, $urandom,
                     $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40));
            end else begin
                send(K_CLEAR, $urandom, $urandom, $urandom);
                even_odd = $urandom_range(0, 1);
            end
        end
    endtask

    initial begin
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        burst_left      = 0;
        start_node      = NODE_W'(1);
        rst_n           = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty store, query before a run, odd cycle, self-loops, clear.
        send(K_QUERY, 0, 0, 0);
        send(K_RUN, 0, 0, 0);
        send(K_ADD, 1, 2, 0);
        send(K_ADD, 2, 3, 0);
        send(K_QUERY, 0, 0, 1);
        send(K_RUN, 0, 0, 0);
        send(K_QUERY, 0, 0, 0);
        send(K_QUERY, 0, 0, 1);
        send(K_QUERY, 0, 0, 1023);
        send(K_ADD, 5, 5, 0);
        send(K_ADD, 1023, 0, 0);
        send(K_RUN, 0, 0, 0);
        send(K_ADD, 3, 1, 0);
        send(K_RUN, 0, 0, 0);
        send(K_QUERY, 0, 0, 4);
        send(K_CLEAR, 1023, 1023, 1023);
        send(K_QUERY, 0, 0, 0);
        send(K_ADD, 1, 1, 1023);
        send(K_RUN, 1023, 1023, 0);
        send(K_QUERY, 0, 0, 0);
        send(K_CLEAR, 0, 0, 0);
        send(K_RUN, 0, 0, 0);

        set_start(NODE_W'(0));
        random_phase(260, 16);
        set_start(NODE_W'(1023));
        random_phase(260, 12);
        set_start(NODE_W'($urandom));
        random_phase(270, 24);

        // Load a wider even-odd graph, then query its last edge and a random index.
        set_start(NODE_W'(0));
        send(K_CLEAR, 0, 0, 0);
        for (int n = 0; n < 20; n++)
            send(K_ADD, 2 * $urandom_range(0, 200), 2 * $urandom_range(0, 200) + 1, 0);
        send(K_RUN, 0, 0, 0);
        send(K_QUERY, 0, 0, 19);
        send(K_QUERY, 0, 0, $urandom);
        send(K_CLEAR, 0, 0, 0);
        send(K_ADD, 0, 1, 0);
        send(K_RUN, 0, 0, 0);
        send(K_QUERY, 0, 0, 0);

        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fails == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
